// File: hw/rtl/lgs_pkg.sv
// ----------------------------------------------------------------------------
// lgs_pkg
// Shared constants for the life grid generation step block: default grid
// size, index and opcode widths, and operation codes.
// ----------------------------------------------------------------------------
package lgs_pkg;

  localparam int unsigned GridRowsDef = 32;
  localparam int unsigned GridColsDef = 32;

  localparam int unsigned OpW = 2;
  localparam int unsigned IdxW = 5;

  localparam logic [OpW-1:0] OP_STEP   = 2'd0;
  localparam logic [OpW-1:0] OP_TOGGLE = 2'd1;
  localparam logic [OpW-1:0] OP_READ   = 2'd2;

endpackage

// File: hw/rtl/life_grid_generation_step.sv
// ----------------------------------------------------------------------------
// life_grid_generation_step
// Bounded Conway Life grid (B3/S23, dead border) held in a row-wide
// synchronous RAM. Step, toggle and read transactions, one result each.
// ----------------------------------------------------------------------------
//  channel   | handshake                 | payload
//  ----------+---------------------------+-------------------------
//  command   | start_i, busy_o           | op_i, row_i, col_i
//  result    | result_valid_o (1 cycle)  | cell_alive_o
//
//  Toggle/read: busy_o is high during the modify state (RAM read issued at
//  the accepting edge, then modify and write back); the registered strobe follows.
//  Step: busy_o is high for the row sweep, then the registered strobe follows;
//  one row read and one row written per cycle through a three-row register
//  window, so the RAM port sets the rate.
//  The result strobe follows the last busy cycle; a new command may be taken
//  in the same cycle. The receiver cannot stall.
//  After reset a clearing pass writes every row to zero, with busy_o high.
// ----------------------------------------------------------------------------
module life_grid_generation_step
  import lgs_pkg::*;
#(
  parameter int unsigned GRID_ROWS = GridRowsDef,
  parameter int unsigned GRID_COLS = GridColsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [OpW-1:0]  op_i,
  input  logic [IdxW-1:0] row_i,
  input  logic [IdxW-1:0] col_i,
  output logic            busy_o,
  output logic            result_valid_o,
  output logic            cell_alive_o
);

  localparam int unsigned RW   = $clog2(GRID_ROWS);
  localparam int unsigned CW   = $clog2(GRID_COLS);
  localparam int unsigned CNTW = $clog2(GRID_ROWS + 1);
  localparam int unsigned RXW  = (RW > IdxW) ? RW : IdxW;
  localparam int unsigned CXW  = (CW > IdxW) ? CW : IdxW;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_RMW   = 2'd2;
  localparam logic [1:0] ST_STEP  = 2'd3;

  // row RAM
  logic [GRID_COLS-1:0] mem_q [GRID_ROWS];
  logic [GRID_COLS-1:0] mem_rdata_q;
  logic                 mem_we, mem_re;
  logic [RW-1:0]        mem_waddr, mem_raddr;
  logic [GRID_COLS-1:0] mem_wdata;

  logic [1:0]      state_q, state_d;
  logic [CNTW-1:0] cnt_q, cnt_d, cnt_m1;
  logic            valid_q, valid_d;
  logic            alive_q, alive_d;
  logic            hit_q, hit_d, hit_now;

  logic [OpW-1:0]       op_q, op_d;
  logic [RW-1:0]        row_q, row_d;
  logic [CW-1:0]        col_q, col_d;
  logic                 inside_q, inside_d;
  logic [GRID_COLS-1:0] prev_q, prev_d, cur_q, cur_d;

  logic [RXW-1:0]       row_x;
  logic [CXW-1:0]       col_x;
  logic                 inside_in;
  logic [GRID_COLS-1:0] below;
  logic [GRID_COLS-1:0] next_row;
  logic [GRID_COLS+1:0] ext_a, ext_m, ext_b;
  logic                 tog;

  assign row_x     = RXW'(row_i);
  assign col_x     = CXW'(col_i);
  assign inside_in = (32'(row_i) < 32'(GRID_ROWS)) && (32'(col_i) < 32'(GRID_COLS));
  assign cnt_m1    = cnt_q - 1'b1;

  // window: row above, current row, row below (zero past the last row)
  assign below = (cnt_q < CNTW'(GRID_ROWS)) ? mem_rdata_q : '0;
  assign ext_a = {1'b0, prev_q, 1'b0};
  assign ext_m = {1'b0, cur_q, 1'b0};
  assign ext_b = {1'b0, below, 1'b0};

  always_comb begin
    logic [3:0] n;
    for (int c = 0; c < GRID_COLS; c++) begin
      n = 4'(ext_a[c]) + 4'(ext_a[c+1]) + 4'(ext_a[c+2])
        + 4'(ext_m[c]) + 4'(ext_m[c+2])
        + 4'(ext_b[c]) + 4'(ext_b[c+1]) + 4'(ext_b[c+2]);
      next_row[c] = (n == 4'd3) || ((n == 4'd2) && cur_q[c]);
    end
  end

  assign tog     = (op_q == OP_TOGGLE) && inside_q;
  assign hit_now = (inside_q && (cnt_q != '0) && (cnt_m1[RW-1:0] == row_q))
                   ? next_row[col_q] : hit_q;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    valid_d   = 1'b0;
    alive_d   = 1'b0;
    hit_d     = hit_q;
    op_d      = op_q;
    row_d     = row_q;
    col_d     = col_q;
    inside_d  = inside_q;
    prev_d    = prev_q;
    cur_d     = cur_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = '0;
    mem_raddr = '0;
    mem_wdata = '0;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q[RW-1:0];
        if (cnt_q == CNTW'(GRID_ROWS - 1)) begin
          state_d = ST_IDLE;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          op_d     = op_i;
          row_d    = inside_in ? row_x[RW-1:0] : '0;
          col_d    = inside_in ? col_x[CW-1:0] : '0;
          inside_d = inside_in;
          cnt_d    = '0;
          prev_d   = '0;
          cur_d    = '0;
          hit_d    = 1'b0;
          mem_re   = 1'b1;
          if (op_i == OP_STEP) begin
            mem_raddr = '0;
            state_d   = ST_STEP;
          end else begin
            mem_raddr = inside_in ? row_x[RW-1:0] : '0;
            state_d   = ST_RMW;
          end
        end
      end
      ST_RMW: begin
        if (tog) begin
          mem_we    = 1'b1;
          mem_waddr = row_q;
          mem_wdata = mem_rdata_q ^ (GRID_COLS'(1) << col_q);
        end
        valid_d = 1'b1;
        alive_d = inside_q && (mem_rdata_q[col_q] ^ tog);
        state_d = ST_IDLE;
      end
      ST_STEP: begin
        // write next state of the previous row, read two rows ahead of it
        if (cnt_q != '0) begin
          mem_we    = 1'b1;
          mem_waddr = cnt_m1[RW-1:0];
          mem_wdata = next_row;
        end
        if (cnt_q < CNTW'(GRID_ROWS - 1)) begin
          mem_re    = 1'b1;
          mem_raddr = RW'(cnt_q + 1'b1);
        end
        hit_d  = hit_now;
        prev_d = cur_q;
        cur_d  = below;
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == CNTW'(GRID_ROWS)) begin
          valid_d = 1'b1;
          alive_d = hit_now;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    if (mem_re) mem_rdata_q <= mem_q[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      cnt_q   <= '0;
      valid_q <= 1'b0;
      alive_q <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      valid_q <= valid_d;
      alive_q <= alive_d;
      hit_q   <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    row_q    <= row_d;
    col_q    <= col_d;
    inside_q <= inside_d;
    prev_q   <= prev_d;
    cur_q    <= cur_d;
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign result_valid_o = valid_q;
  assign cell_alive_o   = alive_q;

  // no RAM write from idle
  a_no_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !mem_we)
    else $error("RAM write while idle");

  // a result only follows a busy cycle
  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy_o))
    else $error("result strobe without a transaction in flight");

  a_alive_qualified: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !result_valid_o |-> !cell_alive_o)
    else $error("cell_alive_o high without strobe");

  // sweep never reads the row it is writing
  a_step_addr_apart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STEP && mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("sweep read and write collide");

endmodule
